/* src/swg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package swg_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 10;

	// internal fixed point
	localparam int QS    = 28;
	localparam int AW    = FRAC_BITS + 5;           // clamped exponent argument
	localparam int TW    = QS + 6;                  // base-2 argument
	localparam int NW    = 6;                       // integer part of t
	localparam int FW    = QS + 1;                  // fraction part of t
	localparam int PW    = QS + 4;                  // polynomial accumulator
	localparam int MW    = QS + 1;                  // final polynomial, unsigned
	localparam int NMAX  = 15;
	localparam int EW    = MW + NMAX;               // 2^n * 2^f
	localparam int DENW  = EW + 1;                  // 1 + exp
	localparam int NUMW  = 2 * QS + 1;              // dividend with rounding term
	localparam int QW    = QS + 1;                  // sigmoid quotient
	localparam int PRODW = 2 * DATA_WIDTH - 1;      // |x| * |y|
	localparam int FULLW = PRODW + QW;
	localparam int MAGW  = FULLW - (QS + FRAC_BITS);
	localparam int HSTEPS = 4;

	localparam logic signed [AW-1:0] CLAMP_POS = AW'(10 <<< FRAC_BITS);
	localparam logic signed [AW-1:0] CLAMP_NEG = -CLAMP_POS;

	localparam logic signed [PW-1:0] Q_ONE   = PW'(64'd1 << QS);
	localparam logic signed [PW-1:0] Q_HALF  = PW'(64'd1 << (QS - 1));
	localparam logic signed [PW-1:0] K_LOG2E = PW'(387270501);
	localparam logic signed [PW-1:0] K_LN2   = PW'(186065280);
	localparam logic signed [PW-1:0] K_C2    = PW'(64485312);
	localparam logic signed [PW-1:0] K_C3    = PW'(14899271);
	localparam logic signed [PW-1:0] K_C4    = PW'(2581847);

	localparam logic signed [PW-1:0] HORNER_K [0:HSTEPS-1] = '{K_C3, K_C2, K_LN2, Q_ONE};

	typedef struct packed {
		logic [PRODW-1:0] prod;
		logic             neg;
		logic             last;
	} tag_t;

endpackage
`default_nettype wire

/* src/swg_exp.sv */
`timescale 1ns / 1ps
`default_nettype none
module swg_exp (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               en,
	input  wire                               in_valid,
	input  wire  signed [swg_pkg::DATA_WIDTH-1:0] gate,
	input  swg_pkg::tag_t                     tag_in,
	output logic                              out_valid,
	output logic [swg_pkg::DENW-1:0]          den,
	output swg_pkg::tag_t                     tag_out
);
	import swg_pkg::*;

	localparam int STAGES = 4 + HSTEPS;

	logic [STAGES-1:0] valid_s;
	tag_t              tag_s [0:STAGES-1];

	logic signed [DATA_WIDTH:0]    neg_x;
	logic signed [AW-1:0]          a_s1;
	logic signed [TW-1:0]          t_s2;
	logic signed [AW+PW-1:0]       t_full;
	logic signed [TW-1:0]          t_rnd;
	logic signed [NW-1:0]          n_s [0:HSTEPS];
	logic signed [FW-1:0]          f_s [0:HSTEPS];
	logic signed [PW-1:0]          p_s [0:HSTEPS];
	logic [MW-1:0]                 p_u;
	logic [EW-1:0]                 e_val;

	assign neg_x  = -$signed({gate[DATA_WIDTH-1], gate});
	assign t_full = a_s1 * K_LOG2E;
	assign t_rnd  = t_s2 + TW'(Q_HALF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= tag_in;
			for (int i = 1; i < STAGES; i++) begin
				tag_s[i] <= tag_s[i-1];
			end
			if (neg_x > $signed({{(DATA_WIDTH+1-AW){CLAMP_POS[AW-1]}}, CLAMP_POS})) begin
				a_s1 <= CLAMP_POS;
			end else if (neg_x < $signed({{(DATA_WIDTH+1-AW){CLAMP_NEG[AW-1]}}, CLAMP_NEG})) begin
				a_s1 <= CLAMP_NEG;
			end else begin
				a_s1 <= AW'(neg_x);
			end
			t_s2 <= TW'(t_full >>> FRAC_BITS);
			// split t into round(t) and a fraction in [-1/2, 1/2)
			n_s[0] <= NW'(t_rnd >>> QS);
			f_s[0] <= $signed({1'b0, t_rnd[QS-1:0]}) - FW'(Q_HALF);
			p_s[0] <= K_C4;
		end
	end

	genvar h;
	generate
		for (h = 0; h < HSTEPS; h++) begin : g_horner
			logic signed [PW+FW-1:0] prod;
			assign prod = p_s[h] * f_s[h];
			always_ff @(posedge clk) begin
				if (en) begin
					n_s[h+1] <= n_s[h];
					f_s[h+1] <= f_s[h];
					p_s[h+1] <= PW'(prod >>> QS) + HORNER_K[h];
				end
			end
		end
	endgenerate

	assign p_u = p_s[HSTEPS][MW-1:0];

	always_comb begin
		if (n_s[HSTEPS] >= 0) begin
			e_val = EW'(p_u) << n_s[HSTEPS][NW-2:0];
		end else begin
			e_val = EW'(p_u) >> NW'(-n_s[HSTEPS]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den <= DENW'(Q_ONE) + DENW'(e_val);
		end
	end

	assign out_valid = valid_s[STAGES-1];
	assign tag_out   = tag_s[STAGES-1];

endmodule
`default_nettype wire

/* src/swg_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module swg_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire                       in_valid,
	input  wire  [swg_pkg::DENW-1:0]  den,
	input  swg_pkg::tag_t             tag_in,
	output logic                      out_valid,
	output logic [swg_pkg::QW-1:0]    quot,
	output swg_pkg::tag_t             tag_out
);
	import swg_pkg::*;

	// one quotient bit per stage, most significant first
	logic [QW-1:0]   valid_s;
	logic [DENW-1:0] rem_s  [0:QW];
	logic [DENW-1:0] den_s  [0:QW];
	logic [NUMW-1:0] num_s  [0:QW];
	logic [QW-1:0]   quot_s [0:QW];
	tag_t            tag_s  [0:QW];
	logic [NUMW-1:0] num_in;

	// round half up: 2^56 + den/2
	assign num_in   = (NUMW'(1) << (2 * QS)) + NUMW'(den >> 1);
	assign rem_s[0] = DENW'(num_in[NUMW-1:QW]);
	assign den_s[0] = den;
	assign num_s[0] = num_in;
	assign quot_s[0] = '0;
	assign tag_s[0] = tag_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[QW-2:0], in_valid};
		end
	end

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			logic [DENW:0] trial;
			logic          ge;
			assign trial = {rem_s[k], num_s[k][QW-1-k]};
			assign ge    = trial >= {1'b0, den_s[k]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= ge ? DENW'(trial - {1'b0, den_s[k]}) : DENW'(trial);
					den_s[k+1]  <= den_s[k];
					num_s[k+1]  <= num_s[k];
					quot_s[k+1] <= {quot_s[k][QW-2:0], ge};
					tag_s[k+1]  <= tag_s[k];
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[QW-1];
	assign quot      = quot_s[QW];
	assign tag_out   = tag_s[QW];

endmodule
`default_nettype wire

/* src/swiglu_gated_activation.sv */
`timescale 1ns / 1ps
`default_nettype none
// SwiGLU gated activation: activated_value = x * y * sigmoid(x), signed Q5.10.
// Input channel: in_valid / in_stall with gate_value (x), up_value (y) and
// last_element; output channel: out_valid / out_stall with activated_value,
// saturated and last_out. last_element rides along unchanged to last_out.
// A result that does not fit 16 bits is clipped and flagged by saturated.
// Throughput: one element per cycle while in_stall is low. Path from transfer
// in to the result on the output register: 1 + exp(-x) is formed (clamp,
// base-2 conversion, split, four Horner steps, scaling), then passes
// through the pipelined restoring divider that yields sigmoid one quotient
// bit per stage, then a multiply stage and a round/saturate stage.
// The whole pipeline advances together; it holds while out_valid is high and
// out_stall is asserted, and in_stall is raised for exactly those cycles.
// Elements in flight are never dropped or repeated.
// Reset clears all valid bits; out_valid is low after reset and the block
// accepts an element in the first cycle after reset is released.
module swiglu_gated_activation (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  signed [swg_pkg::DATA_WIDTH-1:0] gate_value,
	input  wire  signed [swg_pkg::DATA_WIDTH-1:0] up_value,
	input  wire                                   last_element,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [swg_pkg::DATA_WIDTH-1:0] activated_value,
	output logic                                  saturated,
	output logic                                  last_out
);
	import swg_pkg::*;

	localparam logic [MAGW-1:0] POS_MAX = MAGW'((64'd1 << (DATA_WIDTH - 1)) - 1);
	localparam logic [MAGW-1:0] NEG_MAX = MAGW'(64'd1 << (DATA_WIDTH - 1));
	localparam logic [FULLW-1:0] RND = FULLW'(1) << (QS + FRAC_BITS - 1);

	logic                  en;
	logic [DATA_WIDTH-1:0] ax;
	logic [DATA_WIDTH-1:0] ay;
	tag_t                  tag_in;
	logic                  exp_valid;
	logic [DENW-1:0]       den;
	tag_t                  exp_tag;
	logic                  div_valid;
	logic [QW-1:0]         sig;
	tag_t                  div_tag;
	logic                  valid_s1;
	logic [FULLW-1:0]      full_s1;
	logic                  neg_s1;
	logic                  last_s1;
	logic [FULLW-1:0]      full_rnd;
	logic [MAGW-1:0]       mag;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign ax = gate_value[DATA_WIDTH-1] ? DATA_WIDTH'(-gate_value) : gate_value;
	assign ay = up_value[DATA_WIDTH-1] ? DATA_WIDTH'(-up_value) : up_value;
	assign tag_in.prod = PRODW'(ax) * PRODW'(ay);
	assign tag_in.neg  = gate_value[DATA_WIDTH-1] ^ up_value[DATA_WIDTH-1];
	assign tag_in.last = last_element;

	swg_exp u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.gate      (gate_value),
		.tag_in    (tag_in),
		.out_valid (exp_valid),
		.den       (den),
		.tag_out   (exp_tag)
	);

	swg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (exp_valid),
		.den       (den),
		.tag_in    (exp_tag),
		.out_valid (div_valid),
		.quot      (sig),
		.tag_out   (div_tag)
	);

	assign full_rnd = full_s1 + RND;
	assign mag      = full_rnd[FULLW-1:QS+FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= div_valid;
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s1 <= FULLW'(div_tag.prod) * FULLW'(sig);
			neg_s1  <= div_tag.neg;
			last_s1 <= div_tag.last;
			last_out <= last_s1;
			if (neg_s1) begin
				if (mag > NEG_MAX) begin
					activated_value <= DATA_WIDTH'(-NEG_MAX);
					saturated       <= 1'b1;
				end else begin
					activated_value <= DATA_WIDTH'(-mag);
					saturated       <= 1'b0;
				end
			end else begin
				if (mag > POS_MAX) begin
					activated_value <= DATA_WIDTH'(POS_MAX);
					saturated       <= 1'b1;
				end else begin
					activated_value <= DATA_WIDTH'(mag);
					saturated       <= 1'b0;
				end
			end
		end
	end

endmodule
`default_nettype wire
